// ===== rtl/core/servo_channel_smoothing_deadband_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Servo smoothing unit assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_CHANNEL_SMOOTHING_DEADBAND_UNIT_ASSERT_SVH
`define SERVO_CHANNEL_SMOOTHING_DEADBAND_UNIT_ASSERT_SVH

// same-cycle implication
`define SCSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/scsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo smoothing unit package
// Widths, register map, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package scsd_pkg;

    localparam int unsigned NUM_CHANNELS_DEF = 4;
    localparam int unsigned CHAN_IDX_W       = 4;   // holds up to 16 channels

    localparam int unsigned CHANNEL_W  = 2;
    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned AVG_W      = 20;
    localparam int unsigned ALPHA_W    = 9;
    localparam int unsigned ANGLE_W    = 8;
    localparam int unsigned PULSE_W    = 12;
    localparam int unsigned DEADBAND_W = 8;
    localparam int unsigned QUOT_W     = 12;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;
    localparam logic [ANGLE_W-1:0] ANGLE_FULL = 8'd180;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ALPHA      = 3'd0;
    localparam logic [2:0] REG_SPAN_LOW   = 3'd1;
    localparam logic [2:0] REG_SPAN_HIGH  = 3'd2;
    localparam logic [2:0] REG_PULSE_ZERO = 3'd3;
    localparam logic [2:0] REG_PULSE_FULL = 3'd4;
    localparam logic [2:0] REG_DEADBAND   = 3'd5;

    localparam logic [ALPHA_W-1:0]    ALPHA_RST      = 9'd51;
    localparam logic [SAMPLE_W-1:0]   SPAN_LOW_RST   = 12'd100;
    localparam logic [SAMPLE_W-1:0]   SPAN_HIGH_RST  = 12'd3900;
    localparam logic [PULSE_W-1:0]    PULSE_ZERO_RST = 12'd1000;
    localparam logic [PULSE_W-1:0]    PULSE_FULL_RST = 12'd2000;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST   = 8'd5;

    typedef struct packed {
        logic [ALPHA_W-1:0]    alpha;
        logic [SAMPLE_W-1:0]   span_lo;
        logic [SAMPLE_W-1:0]   span_hi;
        logic [PULSE_W-1:0]    pulse_zero;
        logic [PULSE_W-1:0]    pulse_full;
        logic [DEADBAND_W-1:0] deadband;
    } cfg_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0]  channel;
        logic [SAMPLE_W-1:0]   sample;
        logic [CHAN_IDX_W-1:0] idx;
    } item_t;

    typedef struct packed {
        logic              start;
        logic [AVG_W-1:0]  dividend;
        logic [QUOT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/scsd_channel_if.sv =====
// ----------------------------------------------------------------------------
// Servo smoothing unit channel interfaces
// Valid/ready sample input channel and result output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface scsd_in_if;
    logic                          valid;
    logic                          ready;
    logic [scsd_pkg::CHANNEL_W-1:0] channel;
    logic [scsd_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface scsd_out_if;
    logic                          valid;
    logic                          ready;
    logic [scsd_pkg::CHANNEL_W-1:0] channel_out;
    logic [scsd_pkg::SAMPLE_W-1:0]  filtered_value;
    logic [scsd_pkg::ANGLE_W-1:0]   angle;
    logic [scsd_pkg::PULSE_W-1:0]   pulse_width;
    logic                          pulse_committed;

    modport source (output valid, output channel_out, output filtered_value,
                    output angle, output pulse_width, output pulse_committed,
                    input ready);
    modport sink   (input valid, input channel_out, input filtered_value,
                    input angle, input pulse_width, input pulse_committed,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/scsd_front.sv =====
// ----------------------------------------------------------------------------
// Servo smoothing unit front end
// Registers incoming samples and resolves the channel state index.
// ----------------------------------------------------------------------------
`default_nettype none

module scsd_front #(
    parameter int unsigned NUM_CHANNELS = scsd_pkg::NUM_CHANNELS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    scsd_in_if.sink         samples,
    output scsd_pkg::item_t push_item,
    output logic            push_valid,
    input  logic            push_ready
);

    logic            fr_valid_reg;
    logic            fr_valid_next;
    scsd_pkg::item_t fr_item_reg;
    scsd_pkg::item_t fr_item_next;

    // channel modulo channel count; input is at most 3
    function automatic logic [scsd_pkg::CHAN_IDX_W-1:0] chan_index(
        input logic [scsd_pkg::CHANNEL_W-1:0] ch
    );
        logic [4:0] r;
        r = {3'b000, ch};
        for (int i = 0; i < 4; i++) begin
            if (r >= 5'(NUM_CHANNELS)) begin
                r = r - 5'(NUM_CHANNELS);
            end
        end
        return r[scsd_pkg::CHAN_IDX_W-1:0];
    endfunction

    assign samples.ready = !fr_valid_reg || push_ready;
    assign push_valid    = fr_valid_reg;
    assign push_item     = fr_item_reg;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        fr_item_next  = fr_item_reg;
        if (samples.ready)
        begin
            fr_valid_next = samples.valid;
        end
        if (samples.valid && samples.ready)
        begin
            fr_item_next.channel = samples.channel;
            fr_item_next.sample  = samples.sample;
            fr_item_next.idx     = chan_index(samples.channel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_item_reg <= fr_item_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/scsd_queue.sv =====
// ----------------------------------------------------------------------------
// Servo smoothing unit item queue
// Two-entry FIFO decoupling the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scsd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  scsd_pkg::item_t push_item,
    input  logic            push_valid,
    output logic            push_ready,
    output scsd_pkg::item_t pop_item,
    output logic            pop_valid,
    input  logic            pop_ready
);

    scsd_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/scsd_div.sv =====
// ----------------------------------------------------------------------------
// Servo smoothing unit divider
// Restoring divider, two quotient bits per cycle, 12-bit quotient.
// Caller guarantees dividend < divisor * 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module scsd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  scsd_pkg::div_req_t req,
    output scsd_pkg::div_rsp_t rsp
);

    localparam int unsigned QW = scsd_pkg::QUOT_W;

    logic [QW-1:0] rem_reg;
    logic [QW-1:0] rem_next;
    logic [QW-1:0] shift_reg;
    logic [QW-1:0] shift_next;
    logic [QW-1:0] den_reg;
    logic [QW-1:0] den_next;
    logic [2:0]    cnt_reg;
    logic [2:0]    cnt_next;
    logic          done_reg;
    logic          done_next;
    logic [QW-1:0] rem_mid;
    logic [QW-1:0] rem_end;
    logic          q_hi;
    logic          q_lo;

    function automatic logic [QW:0] div_step(
        input logic [QW-1:0] rem,
        input logic          bit_in,
        input logic [QW-1:0] den
    );
        logic [QW:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, den})
        begin
            trial = trial - {1'b0, den};
            return {1'b1, trial[QW-1:0]};
        end
        return {1'b0, trial[QW-1:0]};
    endfunction

    assign {q_hi, rem_mid} = div_step(rem_reg, shift_reg[QW-1], den_reg);
    assign {q_lo, rem_end} = div_step(rem_mid, shift_reg[QW-2], den_reg);

    assign rsp.done     = done_reg;
    assign rsp.quotient = shift_reg;

    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            rem_next   = {4'b0000, req.dividend[19:12]};
            shift_next = req.dividend[11:0];
            den_next   = req.divisor;
            cnt_next   = 3'(QW / 2);
        end
        else if (cnt_reg != 3'd0)
        begin
            rem_next   = rem_end;
            shift_next = {shift_reg[QW-3:0], q_hi, q_lo};
            cnt_next   = cnt_reg - 3'd1;
            done_next  = (cnt_reg == 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        den_reg   <= den_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/scsd_back.sv =====
// ----------------------------------------------------------------------------
// Servo smoothing unit back end
// Sequencer: average update, span-to-angle, angle-to-pulse, deadband commit.
// ----------------------------------------------------------------------------
`default_nettype none

module scsd_back #(
    parameter int unsigned NUM_CHANNELS = scsd_pkg::NUM_CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  scsd_pkg::cfg_t     cfg,
    input  scsd_pkg::item_t    pop_item,
    input  logic               pop_valid,
    output logic               pop_ready,
    output scsd_pkg::div_req_t div_req,
    input  scsd_pkg::div_rsp_t div_rsp,
    scsd_out_if.source         results
);

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // floor(x / 180) for x < 2^20 as (x * ceil(2^28 / 180)) >> 28
    localparam logic [20:0] RECIP_180 = 21'd1491309;

    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_EMA_A       = 4'd1;
    localparam logic [3:0] ST_EMA_B       = 4'd2;
    localparam logic [3:0] ST_SUM         = 4'd3;
    localparam logic [3:0] ST_SPAN        = 4'd4;
    localparam logic [3:0] ST_ANGLE_DIV   = 4'd5;
    localparam logic [3:0] ST_ANGLE_WAIT  = 4'd6;
    localparam logic [3:0] ST_PULSE_MUL   = 4'd7;
    localparam logic [3:0] ST_PULSE_RECIP = 4'd8;
    localparam logic [3:0] ST_PULSE_ADD   = 4'd9;
    localparam logic [3:0] ST_COMMIT      = 4'd10;

    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    scsd_pkg::item_t       item_reg;
    scsd_pkg::item_t       item_next;
    logic [8:0]            alpha_reg;
    logic [8:0]            alpha_next;
    logic [20:0]           pa_reg;
    logic [20:0]           pa_next;
    logic [28:0]           pb_reg;
    logic [28:0]           pb_next;
    logic [11:0]           whole_reg;
    logic [11:0]           whole_next;
    logic [19:0]           num_reg;
    logic [19:0]           num_next;
    logic [11:0]           den_reg;
    logic [11:0]           den_next;
    logic                  zero_reg;
    logic                  zero_next;
    logic [7:0]            angle_reg;
    logic [7:0]            angle_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [19:0]           mag_reg;
    logic [19:0]           mag_next;
    logic [39:0]           recip_reg;
    logic [39:0]           recip_next;
    logic [11:0]           pulse_reg;
    logic [11:0]           pulse_next;

    logic [19:0]           avg_mem_reg [NUM_CHANNELS];
    logic [11:0]           last_pulse_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] pulse_valid_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            out_channel_reg;
    logic [11:0]           out_filtered_reg;
    logic [7:0]            out_angle_reg;
    logic [11:0]           out_pulse_reg;
    logic                  out_commit_reg;
    logic                  out_load;

    logic [IDX_W-1:0]      idx;
    logic [8:0]            alpha_sat;
    logic [20:0]           avg_sum;
    logic [19:0]           avg_new;
    logic                  avg_we;
    logic                  span_ok;
    logic signed [12:0]    pulse_diff;
    logic signed [21:0]    pulse_prod;
    logic [21:0]           pulse_abs;
    logic [11:0]           pulse_quot;
    logic [11:0]           last_sel;
    logic [11:0]           delta;
    logic                  commit;
    logic                  out_free;

    assign idx        = item_reg.idx[IDX_W-1:0];
    assign alpha_sat  = (cfg.alpha > scsd_pkg::ALPHA_ONE) ? scsd_pkg::ALPHA_ONE : cfg.alpha;
    assign avg_sum    = pa_reg + pb_reg[28:8];
    assign avg_new    = avg_sum[19:0];
    assign span_ok    = (cfg.span_hi > cfg.span_lo) && (whole_reg >= cfg.span_lo);
    assign pulse_diff = $signed({1'b0, cfg.pulse_full}) - $signed({1'b0, cfg.pulse_zero});
    assign pulse_prod = $signed({1'b0, angle_reg}) * pulse_diff;
    assign pulse_abs  = pulse_prod[21] ? 22'(-pulse_prod) : 22'(pulse_prod);
    assign pulse_quot = recip_reg[39:28];
    assign last_sel   = last_pulse_reg[idx];
    assign delta      = (pulse_reg >= last_sel) ? (pulse_reg - last_sel)
                                                : (last_sel - pulse_reg);
    assign commit     = !pulse_valid_reg[idx] || (delta > {4'd0, cfg.deadband});
    assign out_free   = !out_valid_reg || results.ready;

    assign results.valid           = out_valid_reg;
    assign results.channel_out     = out_channel_reg;
    assign results.filtered_value  = out_filtered_reg;
    assign results.angle           = out_angle_reg;
    assign results.pulse_width     = out_pulse_reg;
    assign results.pulse_committed = out_commit_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        alpha_next     = alpha_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        whole_next     = whole_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        zero_next      = zero_reg;
        angle_next     = angle_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        recip_next     = recip_reg;
        pulse_next     = pulse_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        avg_we         = 1'b0;
        pop_ready      = 1'b0;
        div_req        = '0;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    item_next  = pop_item;
                    alpha_next = alpha_sat;
                    state_next = ST_EMA_A;
                end
            end
            ST_EMA_A:
            begin
                pa_next    = {12'd0, alpha_reg} * {9'd0, item_reg.sample};
                state_next = ST_EMA_B;
            end
            ST_EMA_B:
            begin
                pb_next    = {20'd0, scsd_pkg::ALPHA_ONE - alpha_reg} * {9'd0, avg_mem_reg[idx]};
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                avg_we     = 1'b1;
                whole_next = avg_new[19:8];
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                num_next   = {8'd0, whole_reg - cfg.span_lo} * {12'd0, scsd_pkg::ANGLE_FULL};
                den_next   = cfg.span_hi - cfg.span_lo;
                zero_next  = !span_ok;
                state_next = ST_ANGLE_DIV;
            end
            ST_ANGLE_DIV:
            begin
                if (zero_reg)
                begin
                    angle_next = 8'd0;
                    state_next = ST_PULSE_MUL;
                end
                else if ({4'd0, num_reg[19:12]} >= den_reg)
                begin
                    angle_next = scsd_pkg::ANGLE_FULL;
                    state_next = ST_PULSE_MUL;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = num_reg;
                    div_req.divisor  = den_reg;
                    state_next       = ST_ANGLE_WAIT;
                end
            end
            ST_ANGLE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    angle_next = (div_rsp.quotient > {4'd0, scsd_pkg::ANGLE_FULL})
                               ? scsd_pkg::ANGLE_FULL : div_rsp.quotient[7:0];
                    state_next = ST_PULSE_MUL;
                end
            end
            ST_PULSE_MUL:
            begin
                neg_next   = pulse_prod[21];
                mag_next   = pulse_abs[19:0];
                state_next = ST_PULSE_RECIP;
            end
            ST_PULSE_RECIP:
            begin
                recip_next = {20'd0, mag_reg} * {19'd0, RECIP_180};
                state_next = ST_PULSE_ADD;
            end
            ST_PULSE_ADD:
            begin
                pulse_next = neg_reg ? (cfg.pulse_zero - pulse_quot)
                                     : (cfg.pulse_zero + pulse_quot);
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            pulse_valid_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                avg_mem_reg[i]    <= '0;
                last_pulse_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (avg_we)
            begin
                avg_mem_reg[idx] <= avg_new;
            end
            if (out_load && commit)
            begin
                last_pulse_reg[idx]  <= pulse_reg;
                pulse_valid_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        alpha_reg <= alpha_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        whole_reg <= whole_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        zero_reg  <= zero_next;
        angle_reg <= angle_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        recip_reg <= recip_next;
        pulse_reg <= pulse_next;
        if (out_load)
        begin
            out_channel_reg  <= item_reg.channel;
            out_filtered_reg <= whole_reg;
            out_angle_reg    <= angle_reg;
            out_pulse_reg    <= pulse_reg;
            out_commit_reg   <= commit;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/servo_channel_smoothing_deadband_unit.sv =====
// ----------------------------------------------------------------------------
// Servo channel smoothing and deadband unit
// Per-channel moving average of ADC samples, mapped to angle and pulse width,
// with deadband-gated pulse commit. APB register block at this level.
//
//   port      dir   protocol    transaction
//   samples   in    valid/ready channel + 12-bit sample
//   results   out   valid/ready channel, average, angle, pulse, commit flag
//   apb       in    APB r/w     register index paddr[4:2], 32-bit data
//
// The angle divide (2 quotient bits per cycle) runs unless the span is empty,
// the average lies below it or the quotient would exceed 12 bits. Front
// register and 2-entry queue take new samples while the back end works. A
// result waiting in the output register stalls only the commit step. Reset
// clears all channel state at once.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_channel_smoothing_deadband_unit #(
    parameter int unsigned NUM_CHANNELS = scsd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scsd_pkg::ADDR_W-1:0] paddr,
    input  logic [scsd_pkg::DATA_W-1:0] pwdata,
    output logic [scsd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    scsd_in_if.sink                     samples,
    scsd_out_if.source                  results
);

    scsd_pkg::cfg_t     cfg_reg;
    scsd_pkg::cfg_t     cfg_next;
    logic [2:0]         reg_idx;
    logic               wr_en;
    scsd_pkg::item_t    push_item;
    logic               push_valid;
    logic               push_ready;
    scsd_pkg::item_t    pop_item;
    logic               pop_valid;
    logic               pop_ready;
    scsd_pkg::div_req_t div_req;
    scsd_pkg::div_rsp_t div_rsp;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                scsd_pkg::REG_ALPHA:      cfg_next.alpha      = pwdata[8:0];
                scsd_pkg::REG_SPAN_LOW:   cfg_next.span_lo    = pwdata[11:0];
                scsd_pkg::REG_SPAN_HIGH:  cfg_next.span_hi    = pwdata[11:0];
                scsd_pkg::REG_PULSE_ZERO: cfg_next.pulse_zero = pwdata[11:0];
                scsd_pkg::REG_PULSE_FULL: cfg_next.pulse_full = pwdata[11:0];
                scsd_pkg::REG_DEADBAND:   cfg_next.deadband   = pwdata[7:0];
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            scsd_pkg::REG_ALPHA:      prdata = {23'd0, cfg_reg.alpha};
            scsd_pkg::REG_SPAN_LOW:   prdata = {20'd0, cfg_reg.span_lo};
            scsd_pkg::REG_SPAN_HIGH:  prdata = {20'd0, cfg_reg.span_hi};
            scsd_pkg::REG_PULSE_ZERO: prdata = {20'd0, cfg_reg.pulse_zero};
            scsd_pkg::REG_PULSE_FULL: prdata = {20'd0, cfg_reg.pulse_full};
            scsd_pkg::REG_DEADBAND:   prdata = {24'd0, cfg_reg.deadband};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha      <= scsd_pkg::ALPHA_RST;
            cfg_reg.span_lo    <= scsd_pkg::SPAN_LOW_RST;
            cfg_reg.span_hi    <= scsd_pkg::SPAN_HIGH_RST;
            cfg_reg.pulse_zero <= scsd_pkg::PULSE_ZERO_RST;
            cfg_reg.pulse_full <= scsd_pkg::PULSE_FULL_RST;
            cfg_reg.deadband   <= scsd_pkg::DEADBAND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scsd_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    scsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    scsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    scsd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .results   (results)
    );

endmodule

`default_nettype wire

// ===== rtl/core/scsd_checker.sv =====
// ----------------------------------------------------------------------------
// Servo smoothing unit port checker
// Port-level assertions on result range, transaction counts and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_channel_smoothing_deadband_unit_assert.svh"

module scsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_channel,
    input logic [11:0] out_filtered,
    input logic [7:0]  out_angle,
    input logic [11:0] out_pulse,
    input logic        out_commit
);

    logic        in_acc;
    logic        out_acc;
    logic [2:0]  pending_reg;
    logic [2:0]  pending_next;
    logic [34:0] out_payload;

    assign in_acc      = in_valid && in_ready;
    assign out_acc     = out_valid && out_ready;
    assign out_payload = {out_channel, out_filtered, out_angle, out_pulse, out_commit};

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `SCSD_ASSERT_NOW(a_angle_range, out_valid, out_angle <= 8'd180, "angle above 180")
    `SCSD_ASSERT_NOW(a_no_phantom, out_acc, pending_reg != 3'd0, "result without sample")
    `SCSD_ASSERT_NOW(a_bounded, in_acc, pending_reg < 3'd5, "too many samples in flight")
    `SCSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "stalled result changed")

endmodule

bind servo_channel_smoothing_deadband_unit scsd_checker u_scsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_channel  (results.channel_out),
    .out_filtered (results.filtered_value),
    .out_angle    (results.angle),
    .out_pulse    (results.pulse_width),
    .out_commit   (results.pulse_committed)
);

`default_nettype wire

// ===== test/scsd_result_checker.sv =====
// ----------------------------------------------------------------------------
// Servo smoothing unit result checker
// Tracks register writes, predicts one result per accepted sample from its own
// per-channel average and pulse state, and compares each accepted result with
// the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module scsd_result_checker
    import scsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    scsd_in_if                samples,
    scsd_out_if               results,
    output int unsigned       mismatches,
    output int unsigned       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  filtered;
        logic [ANGLE_W-1:0]   angle;
        logic [PULSE_W-1:0]   pulse;
        logic                 committed;
    } servo_result_t;

    cfg_t               settings;
    logic [AVG_W-1:0]   average    [NUM_CHANNELS_DEF];
    logic [PULSE_W-1:0] held_pulse [NUM_CHANNELS_DEF];
    logic               held_valid [NUM_CHANNELS_DEF];
    servo_result_t      servo_results_due[$];

    function automatic logic [ANGLE_W-1:0] angle_of(logic [SAMPLE_W-1:0] whole);
        int q;
        if (settings.span_hi <= settings.span_lo || whole < settings.span_lo)
            return '0;
        q = ((int'(whole) - int'(settings.span_lo)) * int'(ANGLE_FULL))
            / (int'(settings.span_hi) - int'(settings.span_lo));
        return (q > int'(ANGLE_FULL)) ? ANGLE_FULL : ANGLE_W'(q);
    endfunction

    // truncates toward zero for a falling pulse range as well
    function automatic logic [PULSE_W-1:0] pulse_of(logic [ANGLE_W-1:0] angle);
        int span;
        int scaled;
        span   = int'(settings.pulse_full) - int'(settings.pulse_zero);
        scaled = (int'(angle) * span) / int'(ANGLE_FULL);
        return PULSE_W'(scaled + int'(settings.pulse_zero));
    endfunction

    function automatic servo_result_t advance_channel(logic [CHANNEL_W-1:0] ch,
                                                      logic [SAMPLE_W-1:0]  s);
        servo_result_t      r;
        int unsigned        slot;
        int unsigned        weight;
        int unsigned        mixed;
        logic [PULSE_W-1:0] gap;
        slot   = ch % NUM_CHANNELS_DEF;
        weight = (settings.alpha > ALPHA_ONE) ? int'(ALPHA_ONE) : int'(settings.alpha);
        mixed  = (weight * (int'(s) << 8)
                  + (int'(ALPHA_ONE) - weight) * int'(average[slot])) >> 8;
        average[slot] = AVG_W'(mixed);
        r.channel  = ch;
        r.filtered = average[slot][AVG_W-1:8];
        r.angle    = angle_of(r.filtered);
        r.pulse    = pulse_of(r.angle);
        gap = (r.pulse >= held_pulse[slot]) ? r.pulse - held_pulse[slot]
                                            : held_pulse[slot] - r.pulse;
        r.committed = !held_valid[slot] || (gap > settings.deadband);
        if (r.committed)
        begin
            held_pulse[slot] = r.pulse;
            held_valid[slot] = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        servo_result_t got;
        servo_result_t want;
        if (!rst_n)
        begin
            settings = '{alpha: ALPHA_RST, span_lo: SPAN_LOW_RST, span_hi: SPAN_HIGH_RST,
                         pulse_zero: PULSE_ZERO_RST, pulse_full: PULSE_FULL_RST,
                         deadband: DEADBAND_RST};
            for (int i = 0; i < NUM_CHANNELS_DEF; i++)
            begin
                average[i]    = '0;
                held_pulse[i] = '0;
                held_valid[i] = 1'b0;
            end
            servo_results_due.delete();
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_ALPHA:      settings.alpha      = pwdata[ALPHA_W-1:0];
                    REG_SPAN_LOW:   settings.span_lo    = pwdata[SAMPLE_W-1:0];
                    REG_SPAN_HIGH:  settings.span_hi    = pwdata[SAMPLE_W-1:0];
                    REG_PULSE_ZERO: settings.pulse_zero = pwdata[PULSE_W-1:0];
                    REG_PULSE_FULL: settings.pulse_full = pwdata[PULSE_W-1:0];
                    REG_DEADBAND:   settings.deadband   = pwdata[DEADBAND_W-1:0];
                    default: ;
                endcase
            end

            if (samples.valid && samples.ready)
                servo_results_due.push_back(advance_channel(samples.channel, samples.sample));

            if (results.valid && results.ready)
            begin
                got = '{channel: results.channel_out, filtered: results.filtered_value,
                        angle: results.angle, pulse: results.pulse_width,
                        committed: results.pulse_committed};
                if (servo_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected transaction ch=%0d filt=%0d ang=%0d pulse=%0d commit=%0b",
                                 $realtime, got.channel, got.filtered, got.angle,
                                 got.pulse, got.committed);
                end
                else
                begin
                    want = servo_results_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch expected ch=%0d filt=%0d ang=%0d pulse=%0d commit=%0b",
                                      " got ch=%0d filt=%0d ang=%0d pulse=%0d commit=%0b"},
                                     $realtime, want.channel, want.filtered, want.angle,
                                     want.pulse, want.committed, got.channel, got.filtered,
                                     got.angle, got.pulse, got.committed);
                    end
                end
            end
            pending <= servo_results_due.size();
        end
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Servo smoothing unit testbench
// Drives tagged ADC samples and register writes, with random idle cycles on
// both channels; a checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scsd_pkg::*;

    localparam logic [2:0]        REG_SPARE = 3'd7;
    localparam logic [DATA_W-1:0] ABOVE_12  = 32'hFFFF_F000;
    localparam logic [DATA_W-1:0] ABOVE_8   = 32'hFFFF_FF00;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              steady = 1'b0;
    int unsigned       mismatches;
    int unsigned       pending;

    logic [SAMPLE_W-1:0] last_sample [NUM_CHANNELS_DEF] = '{default: '0};

    scsd_in_if  sample_bus();
    scsd_out_if result_bus();

    servo_channel_smoothing_deadband_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (sample_bus),
        .results (result_bus)
    );

    scsd_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .samples    (sample_bus),
        .results    (result_bus),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #4 clk = ~clk;
    end

    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_bus.ready <= steady || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        #5ms;
        $display("servo_channel_smoothing_deadband_unit verification failed");
        $finish;
    end

    task automatic apb_write(input logic [2:0] index, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] alpha, input logic [DATA_W-1:0] lo,
                                  input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] p_zero,
                                  input logic [DATA_W-1:0] p_full,
                                  input logic [DATA_W-1:0] band);
        apb_write(REG_ALPHA, alpha);
        apb_write(REG_SPAN_LOW, lo);
        apb_write(REG_SPAN_HIGH, hi);
        apb_write(REG_PULSE_ZERO, p_zero);
        apb_write(REG_PULSE_FULL, p_full);
        apb_write(REG_DEADBAND, band);
    endtask

    task automatic apply_random_settings();
        logic [DATA_W-1:0] alpha;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] swap;
        logic [DATA_W-1:0] band;
        alpha = ($urandom_range(2) == 0) ? $urandom() : $urandom_range(256, 24);
        lo    = $urandom_range(1600);
        hi    = $urandom_range(4095, 1800);
        if ($urandom_range(5) == 0)
        begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        band = $urandom_range(1) ? $urandom_range(12) : $urandom_range(255);
        apply_settings(alpha, lo | ($urandom() & ABOVE_12), hi | ($urandom() & ABOVE_12),
                       $urandom_range(4095) | ($urandom() & ABOVE_12),
                       $urandom_range(4095) | ($urandom() & ABOVE_12),
                       band | ($urandom() & ABOVE_8));
    endtask

    task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
        if (!steady)
        begin
            while ($urandom_range(99) < 30)
            begin
                sample_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        sample_bus.valid   <= 1'b1;
        sample_bus.channel <= ch;
        sample_bus.sample  <= s;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        last_sample[ch] = s;
    endtask

    // mostly slow drift per channel, with jumps and rail values mixed in
    task automatic send_random_sample();
        logic [CHANNEL_W-1:0] ch;
        logic [SAMPLE_W-1:0]  s;
        int                   pick;
        int                   level;
        ch   = CHANNEL_W'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 12)
            s = $urandom_range(1) ? '1 : '0;
        else if (pick < 35)
            s = SAMPLE_W'($urandom());
        else
        begin
            level = int'(last_sample[ch]) + int'($urandom_range(80)) - 40;
            if (level < 0)
                level = 0;
            if (level > 4095)
                level = 4095;
            s = SAMPLE_W'(level);
        end
        send_sample(ch, s);
    endtask

    task automatic drain(input int tail);
        sample_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (tail) @(posedge clk);
    endtask

    initial
    begin
        sample_bus.valid   = 1'b0;
        sample_bus.channel = '0;
        sample_bus.sample  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, first pulse on every channel
        send_sample(2'd0, 12'd0);
        send_sample(2'd1, 12'd4095);
        send_sample(2'd2, 12'd2048);
        send_sample(2'd3, 12'd4095);
        send_sample(2'd0, 12'd4095);
        send_sample(2'd3, 12'd4095);
        drain(40);

        // full weight, falling pulse range, zero deadband
        apply_settings(32'd256, 32'd100, 32'd3900, 32'd2000, 32'd1000, 32'd0);
        send_sample(2'd0, 12'd50);
        send_sample(2'd1, 12'd4095);
        send_sample(2'd2, 12'd3900);
        send_sample(2'd3, 12'd100);
        send_sample(2'd0, 12'd2001);
        send_sample(2'd0, 12'd2001);
        drain(40);

        // weight above one, empty span, spare register
        apply_settings(32'd511, 32'd2000, 32'd2000, 32'd1500, 32'd1600, 32'd255);
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        send_sample(2'd1, 12'd0);
        send_sample(2'd2, 12'd4095);
        send_sample(2'd3, 12'd1234);
        drain(40);

        // zero weight, inverted span
        apply_settings(32'd0, 32'd4095, 32'd0, 32'd4095, 32'd0, 32'd8);
        send_sample(2'd0, 12'd4095);
        send_sample(2'd3, 12'd0);
        drain(40);

        // full-scale span and pulse, widest deadband
        apply_settings(32'd256, 32'd0, 32'd4095, 32'd0, 32'd4095, 32'd255);
        send_sample(2'd1, 12'd0);
        send_sample(2'd1, 12'd4095);
        drain(40);

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                apply_settings(32'd256, 32'd0, 32'd4095, 32'd0, 32'd4095, 32'd0);
            else
                apply_random_settings();
            steady <= (phase == 3);
            repeat (205)
            begin
                send_random_sample();
                if ($urandom_range(149) == 0)
                    drain(0);
            end
            drain(40);
            steady <= 1'b0;
        end

        if (mismatches == 0)
            $display("servo_channel_smoothing_deadband_unit verification clean");
        else
            $display("servo_channel_smoothing_deadband_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
